// ----- src/hrf_pkg.sv -----
// shared types and constants of the request framer
package hrf_pkg;

  localparam int unsigned BURST_MAX = 9;
  localparam int unsigned BURST_CNT_W = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DEV_ADDR_W = 40;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_PAYLOAD = 2'd1;
  localparam logic [1:0] REQ_ABORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_FLAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_FLAG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDR = 3'd4;

  localparam logic [BURST_CNT_W-1:0] SHORT_HDR_LEN = 4'd4;
  localparam logic [BURST_CNT_W-1:0] LONG_HDR_LEN = 4'd8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } hrf_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } hrf_out_t;

  // bytes caused by one item, byte 0 goes out first
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [BURST_CNT_W-1:0]    count;
    logic                      ends;
  } hrf_burst_t;

endpackage

// ----- src/hrf_serializer.sv -----
// emits the bytes of one burst, one per output item
module hrf_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               burst_valid,
  input  hrf_pkg::hrf_burst_t burst,
  output logic               burst_take,
  output logic               out_valid,
  input  logic               out_stall,
  output hrf_pkg::hrf_out_t  out_data
);
  import hrf_pkg::*;

  logic [BURST_MAX-1:0][7:0] bytes_r, bytes_nxt;
  logic [BURST_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                      ends_r, ends_nxt;
  logic                      out_fire;
  logic                      empty_soon;

  assign out_valid = (cnt_r != '0);
  assign out_fire = out_valid && !out_stall;
  assign empty_soon = (cnt_r == '0) || ((cnt_r == BURST_CNT_W'(1)) && out_fire);
  assign burst_take = burst_valid && empty_soon;

  assign out_data.frame_byte = bytes_r[0];
  assign out_data.frame_end = ends_r && (cnt_r == BURST_CNT_W'(1));

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt = cnt_r;
    ends_nxt = ends_r;
    if (burst_take) begin
      bytes_nxt = burst.bytes;
      cnt_nxt = burst.count;
      ends_nxt = burst.ends;
    end else if (out_fire) begin
      bytes_nxt = {8'h00, bytes_r[BURST_MAX-1:1]};
      cnt_nxt = cnt_r - BURST_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    ends_r <= ends_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/hart_request_framer.sv -----
// top level of the request framer: frame state, header build and output stage
//
// Builds master request frames as a stream of bytes.
// in_valid/in_stall/in_data carries request items: start, payload byte or abort.
// out_valid/out_stall/out_data carries one frame byte per item; frame_end marks
// the checksum byte that closes a frame.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes the delimiter, master and
// address registers; cfg_ready is always high. Write only while idle.
// Each accepted item is turned into a burst of 0 to 9 bytes and held in a
// burst register; a serializer then emits the burst one byte per cycle while
// the receiver does not stall. When the output is free, the first byte of a
// burst passes the burst register and then the serializer's byte register.
// Throughput: one item per cycle while items yield at most one byte each and
// the receiver does not stall; an item yielding n bytes (start items 4 to 9)
// holds the output until all n are out; the port moves one byte per cycle.
// When the receiver stalls, the serializer holds its byte; once the burst
// register is full as well, in_stall rises.
// Reset (rst_n low, synchronous) restores register defaults, closes any frame,
// clears the polling address and drops pending bytes.
module hart_request_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hrf_pkg::hrf_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hrf_pkg::hrf_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hrf_pkg::DEV_ADDR_W-1:0] cfg_data
);
  import hrf_pkg::*;

  logic [7:0]            frame_type_r, short_flag_r, long_flag_r, master_r;
  logic [DEV_ADDR_W-1:0] dev_addr_r;

  logic [5:0] poll_r, poll_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       open_r, open_nxt;

  hrf_burst_t burst_r, burst_nxt;
  logic       burst_valid_r, burst_valid_nxt;
  logic       burst_take;
  logic       in_fire;

  logic [7:0] hdr_xor;
  logic [7:0] pay_xor;
  logic [7:0] rem_dec;

  assign cfg_ready = 1'b1;
  assign in_stall = burst_valid_r && !burst_take;
  assign in_fire = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_type_r <= 8'd2;
      short_flag_r <= 8'd0;
      long_flag_r <= 8'd128;
      master_r <= 8'd128;
      dev_addr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_TYPE:  frame_type_r <= cfg_data[7:0];
        CFG_SHORT_FLAG:  short_flag_r <= cfg_data[7:0];
        CFG_LONG_FLAG:   long_flag_r <= cfg_data[7:0];
        CFG_MASTER_BITS: master_r <= cfg_data[7:0];
        CFG_DEVICE_ADDR: dev_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame state and burst build
  always_comb begin
    poll_nxt = poll_r;
    remain_nxt = remain_r;
    xor_nxt = xor_r;
    open_nxt = open_r;
    burst_nxt = '0;
    hdr_xor = '0;
    pay_xor = xor_r ^ in_data.payload_byte;
    rem_dec = remain_r - 8'd1;

    case (in_data.req_type)
      REQ_START: begin
        if (in_data.command == 8'd0) begin
          burst_nxt.bytes[0] = frame_type_r | short_flag_r;
          burst_nxt.bytes[1] = {2'b00, poll_r} | master_r;
          burst_nxt.bytes[2] = in_data.command;
          burst_nxt.bytes[3] = in_data.payload_length;
          burst_nxt.count = SHORT_HDR_LEN;
          poll_nxt = poll_r + 6'd1;
        end else begin
          burst_nxt.bytes[0] = frame_type_r | long_flag_r;
          burst_nxt.bytes[1] = dev_addr_r[39:32] | master_r;
          burst_nxt.bytes[2] = dev_addr_r[31:24];
          burst_nxt.bytes[3] = dev_addr_r[23:16];
          burst_nxt.bytes[4] = dev_addr_r[15:8];
          burst_nxt.bytes[5] = dev_addr_r[7:0];
          burst_nxt.bytes[6] = in_data.command;
          burst_nxt.bytes[7] = in_data.payload_length;
          burst_nxt.count = LONG_HDR_LEN;
        end
        // unused slots are zero, so the xor over all slots is the header xor
        for (int i = 0; i < BURST_MAX; i++) begin
          hdr_xor = hdr_xor ^ burst_nxt.bytes[i];
        end
        if (in_data.payload_length == 8'd0) begin
          burst_nxt.bytes[burst_nxt.count] = hdr_xor;
          burst_nxt.count = burst_nxt.count + BURST_CNT_W'(1);
          burst_nxt.ends = 1'b1;
          open_nxt = 1'b0;
          remain_nxt = '0;
          xor_nxt = '0;
        end else begin
          open_nxt = 1'b1;
          remain_nxt = in_data.payload_length;
          xor_nxt = hdr_xor;
        end
      end
      REQ_PAYLOAD: begin
        if (open_r) begin
          burst_nxt.bytes[0] = in_data.payload_byte;
          if (rem_dec == 8'd0) begin
            burst_nxt.bytes[1] = pay_xor;
            burst_nxt.count = BURST_CNT_W'(2);
            burst_nxt.ends = 1'b1;
            open_nxt = 1'b0;
            remain_nxt = '0;
            xor_nxt = '0;
          end else begin
            burst_nxt.count = BURST_CNT_W'(1);
            remain_nxt = rem_dec;
            xor_nxt = pay_xor;
          end
        end
      end
      REQ_ABORT: begin
        poll_nxt = '0;
        remain_nxt = '0;
        xor_nxt = '0;
        open_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    burst_valid_nxt = burst_valid_r && !burst_take;
    if (in_fire && (burst_nxt.count != '0)) begin
      burst_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      burst_r <= burst_nxt;
    end
    if (!rst_n) begin
      poll_r <= '0;
      remain_r <= '0;
      xor_r <= '0;
      open_r <= 1'b0;
      burst_valid_r <= 1'b0;
    end else begin
      burst_valid_r <= burst_valid_nxt;
      if (in_fire) begin
        poll_r <= poll_nxt;
        remain_r <= remain_nxt;
        xor_r <= xor_nxt;
        open_r <= open_nxt;
      end
    end
  end

  hrf_serializer u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst_valid (burst_valid_r),
    .burst       (burst_r),
    .burst_take  (burst_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- src/hrf_checker.sv -----
// port-level checks of the request framer, bound to the top level
module hrf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input hrf_pkg::hrf_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input hrf_pkg::hrf_out_t             out_data
);
  import hrf_pkg::*;

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // an empty output stage always takes a new item
  a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // every accepted start item is followed by a valid output byte
  a_start_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_START) |-> ##2 out_valid)
    else $error("start item produced no output");

  // reset drops pending bytes
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind hart_request_framer hrf_checker u_hrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
